// File: hw/rtl/abst_pkg.sv
package abst_pkg;

    // Controller states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK
    } t_state;

    // Result status codes
    localparam logic STATUS_STORED = 1'b0;
    localparam logic STATUS_NO_ROOM = 1'b1;

    // Fixed key and result field widths
    localparam int SLOT_OUT_W  = 10;
    localparam int DEPTH_OUT_W = 4;
    localparam int COUNT_W     = 10;
    localparam int KEY_W       = 32;

endpackage

// File: hw/rtl/abst_ram.sv
module abst_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 1023
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/array_bst_insert.sv
// Binary search tree insert over an implicit array (children of slot i are
// 2i+1 and 2i+2), one key per command beat. Keys and per-slot valid bits share
// one RAM with a registered read; the walk reads one slot per cycle. After
// reset a clearing pass writes every slot invalid, with busy high. A key walks
// from the root, reading at most LEVELS slots with busy high, and its result
// appears registered with o_valid after the last slot read. A walk past the
// deepest level returns status no-room and stores nothing. Results are shown
// for one cycle only and cannot be stalled; start is taken whenever busy is
// low.
module array_bst_insert import abst_pkg::*; #(
    parameter int LEVELS = 10
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic signed [KEY_W-1:0] i_key_value,
    output logic                   o_valid,
    output logic                   o_status,
    output logic [SLOT_OUT_W-1:0]  o_slot_index,
    output logic [DEPTH_OUT_W-1:0] o_depth_reached,
    output logic [COUNT_W-1:0]     o_node_total
);

    localparam int SLOTS = (1 << LEVELS) - 1;
    localparam int AW    = LEVELS;
    localparam int DW    = $clog2(LEVELS);
    localparam int MW    = KEY_W + 1;

    t_state r_state, n_state;

    logic [AW-1:0]          r_slot, n_slot;
    logic [DW-1:0]          r_depth, n_depth;
    logic [AW-1:0]          r_clr, n_clr;
    logic signed [KEY_W-1:0] r_key, n_key;
    logic [COUNT_W-1:0]     r_count, n_count;

    logic                   r_valid, n_valid;
    logic                   r_status, n_status;
    logic [SLOT_OUT_W-1:0]  r_slot_out, n_slot_out;
    logic [DEPTH_OUT_W-1:0] r_depth_out, n_depth_out;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [MW-1:0]          ram_wdata;
    logic [AW-1:0]          ram_raddr;
    logic [MW-1:0]          ram_rdata;

    logic                   rd_used;
    logic signed [KEY_W-1:0] rd_key;
    logic                   go_right;
    logic                   last_level;
    logic [AW:0]            child_wide;
    logic [AW+SLOT_OUT_W-1:0] slot_ext;

    // Slot store: {valid, key}
    abst_ram #(
        .WIDTH (MW),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Read data decode and walk direction
    assign rd_used    = ram_rdata[MW-1];
    assign rd_key     = $signed(ram_rdata[KEY_W-1:0]);
    assign go_right   = r_key > rd_key;
    assign last_level = (r_depth == DW'(LEVELS - 1));
    assign child_wide = {r_slot, 1'b0} + ((AW+1)'(go_right) + (AW+1)'(1));
    assign slot_ext   = (AW+SLOT_OUT_W)'(r_slot);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr == AW'(SLOTS - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (start) n_state = ST_WALK;
            end
            ST_WALK: begin
                if (!rd_used || last_level) n_state = ST_IDLE;
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // Datapath, RAM control and result beat
    always_comb begin
        n_slot      = r_slot;
        n_depth     = r_depth;
        n_clr       = r_clr;
        n_key       = r_key;
        n_count     = r_count;
        n_valid     = 1'b0;
        n_status    = r_status;
        n_slot_out  = r_slot_out;
        n_depth_out = r_depth_out;
        ram_we      = 1'b0;
        ram_waddr   = r_slot;
        ram_wdata   = {1'b1, r_key};
        ram_raddr   = r_slot;
        case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
                n_clr     = r_clr + AW'(1);
            end
            ST_IDLE: begin
                // Root read issued with the start beat
                ram_raddr = '0;
                if (start) begin
                    n_key   = i_key_value;
                    n_slot  = '0;
                    n_depth = '0;
                end
            end
            ST_WALK: begin
                ram_raddr = child_wide[AW-1:0];
                if (!rd_used) begin
                    // Free slot: store here
                    ram_we      = 1'b1;
                    n_count     = r_count + COUNT_W'(1);
                    n_valid     = 1'b1;
                    n_status    = STATUS_STORED;
                    n_slot_out  = slot_ext[SLOT_OUT_W-1:0];
                    n_depth_out = DEPTH_OUT_W'(r_depth);
                end else if (last_level) begin
                    n_valid     = 1'b1;
                    n_status    = STATUS_NO_ROOM;
                    n_slot_out  = '0;
                    n_depth_out = '0;
                end else begin
                    n_slot  = child_wide[AW-1:0];
                    n_depth = r_depth + DW'(1);
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_slot      <= n_slot;
        r_depth     <= n_depth;
        r_key       <= n_key;
        r_status    <= n_status;
        r_slot_out  <= n_slot_out;
        r_depth_out <= n_depth_out;
    end

    assign busy            = (r_state != ST_IDLE);
    assign o_valid         = r_valid;
    assign o_status        = r_status;
    assign o_slot_index    = r_slot_out;
    assign o_depth_reached = r_depth_out;
    assign o_node_total    = r_count;

endmodule

// File: dv/abst_checker.sv
// Watches the command and result beats of the tree insert block, keeps its own
// copy of the tree and compares every result beat with the oldest prediction.
module abst_checker import abst_pkg::*; #(
    parameter int LEVELS = 10
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    input  logic                    busy,
    input  logic signed [KEY_W-1:0] i_key_value,
    input  logic                    o_valid,
    input  logic                    o_status,
    input  logic [SLOT_OUT_W-1:0]   o_slot_index,
    input  logic [DEPTH_OUT_W-1:0]  o_depth_reached,
    input  logic [COUNT_W-1:0]      o_node_total,
    output int                      mismatch_count,
    output int                      pending_inserts
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = (1 << LEVELS) - 1;

    typedef struct packed {
        logic                   status;
        logic [SLOT_OUT_W-1:0]  slot;
        logic [DEPTH_OUT_W-1:0] depth;
        logic [COUNT_W-1:0]     total;
    } t_insert_result;

    // Shadow tree: keys, occupancy and count
    logic signed [KEY_W-1:0] node_key [SLOTS];
    bit                      node_used [SLOTS];
    logic [COUNT_W-1:0]      stored_count;
    t_insert_result          expected_inserts [$];

    // Walk from the root, store at the first free slot; equal keys go left
    function automatic t_insert_result predict_insert(input logic signed [KEY_W-1:0] key);
        t_insert_result res;
        int             slot;
        int             depth;
        slot  = 0;
        depth = 0;
        while (depth < LEVELS && slot < SLOTS && node_used[slot]) begin
            slot = (key > node_key[slot]) ? 2 * slot + 2 : 2 * slot + 1;
            depth++;
        end
        if (depth >= LEVELS || slot >= SLOTS) begin
            // every slot on the path taken: nothing stored
            res.status = STATUS_NO_ROOM;
            res.slot   = '0;
            res.depth  = '0;
        end else begin
            node_key[slot]  = key;
            node_used[slot] = 1'b1;
            stored_count    = stored_count + COUNT_W'(1);
            res.status = STATUS_STORED;
            res.slot   = SLOT_OUT_W'(slot);
            res.depth  = DEPTH_OUT_W'(depth);
        end
        res.total = stored_count;
        return res;
    endfunction

    task automatic log_mismatch(input string msg);
        if (mismatch_count < 10)
            $display("%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
            log_mismatch($sformatf("%s mismatch: expected %0d, got %0d", name, want, got));
    endtask

    // Result beats are retired before the command beat of the same edge is predicted
    always @(posedge i_clk) begin : watch_beats
        t_insert_result want;
        if (!i_rst_n) begin
            foreach (node_used[n])
                node_used[n] = 1'b0;
            stored_count = '0;
            expected_inserts.delete();
        end else begin
            if (o_valid) begin
                if (expected_inserts.size() == 0) begin
                    log_mismatch($sformatf(
                        "result beat with no insert pending: status %0d slot %0d depth %0d total %0d",
                        o_status, o_slot_index, o_depth_reached, o_node_total));
                end else begin
                    want = expected_inserts.pop_front();
                    check_field("status", 32'(want.status), 32'(o_status));
                    check_field("slot_index", 32'(want.slot), 32'(o_slot_index));
                    check_field("depth_reached", 32'(want.depth), 32'(o_depth_reached));
                    check_field("node_total", 32'(want.total), 32'(o_node_total));
                end
            end
            if (start && !busy)
                expected_inserts.push_back(predict_insert(i_key_value));
        end
        pending_inserts <= expected_inserts.size();
    end

endmodule

// File: dv/testbench.sv
// Stimulus and verdict for the tree insert block.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import abst_pkg::*;

    localparam int LEVELS     = 10;
    localparam int SLOTS      = (1 << LEVELS) - 1;
    localparam int LEAF_FIRST = (1 << (LEVELS - 1)) - 1;
    localparam int RANDOM_PER_PHASE = 534;
    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;
    localparam longint KEY_MIN_L = -64'sd2147483648;
    localparam longint KEY_MAX_L = 64'sd2147483647;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    start = 1'b0;
    logic signed [KEY_W-1:0] i_key_value = '0;
    logic                    busy;
    logic                    o_valid;
    logic                    o_status;
    logic [SLOT_OUT_W-1:0]   o_slot_index;
    logic [DEPTH_OUT_W-1:0]  o_depth_reached;
    logic [COUNT_W-1:0]      o_node_total;
    int                      mismatch_count;
    int                      pending_inserts;

    // Occupancy picture used to aim keys at free slots
    logic signed [KEY_W-1:0] tree_key [SLOTS];
    bit                      tree_used [SLOTS];
    bit                      tree_right_dead [SLOTS];
    bit                      tree_full [SLOTS];

    array_bst_insert #(.LEVELS(LEVELS)) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_key_value     (i_key_value),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_slot_index    (o_slot_index),
        .o_depth_reached (o_depth_reached),
        .o_node_total    (o_node_total)
    );

    abst_checker #(.LEVELS(LEVELS)) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_key_value     (i_key_value),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_slot_index    (o_slot_index),
        .o_depth_reached (o_depth_reached),
        .o_node_total    (o_node_total),
        .mismatch_count  (mismatch_count),
        .pending_inserts (pending_inserts)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Record where a sent key lands; a right subtree is dead once no key can reach it
    task automatic track_key(input logic signed [KEY_W-1:0] key);
        int     s;
        int     depth;
        longint hi;
        s     = 0;
        depth = 0;
        hi    = KEY_MAX_L;
        while (depth < LEVELS && tree_used[s]) begin
            if (key > tree_key[s]) begin
                s = 2 * s + 2;
            end else begin
                hi = longint'(tree_key[s]);
                s  = 2 * s + 1;
            end
            depth++;
        end
        if (depth < LEVELS) begin
            tree_used[s]       = 1'b1;
            tree_key[s]        = key;
            tree_right_dead[s] = (longint'(key) == hi);
            // refresh fullness up to the root
            forever begin
                tree_full[s] = (s >= LEAF_FIRST) ||
                               (tree_full[2*s+1] && (tree_right_dead[s] || tree_full[2*s+2]));
                if (s == 0)
                    break;
                s = (s - 1) / 2;
            end
        end
    endtask

    // Random descent through subtrees with room; key from the middle of the free interval
    function automatic logic signed [KEY_W-1:0] aimed_key();
        int     s;
        longint lo;
        longint hi;
        longint span;
        bit     go_right;
        s  = 0;
        lo = KEY_MIN_L;
        hi = KEY_MAX_L;
        while (tree_used[s]) begin
            if (tree_full[2*s+1])
                go_right = 1'b1;
            else if (tree_right_dead[s] || tree_full[2*s+2])
                go_right = 1'b0;
            else
                go_right = 1'($urandom_range(1));
            if (go_right) begin
                lo = longint'(tree_key[s]) + 1;
                s  = 2 * s + 2;
            end else begin
                hi = longint'(tree_key[s]);
                s  = 2 * s + 1;
            end
        end
        span = hi - lo;
        return KEY_W'(lo + span / 4 + (longint'($urandom) % (span / 2 + 1)));
    endfunction

    function automatic logic signed [KEY_W-1:0] noise_key();
        case ($urandom_range(7))
            0:       return KEY_MIN;
            1:       return KEY_MAX;
            default: return $urandom;
        endcase
    endfunction

    // One command beat, after an optional random gap
    task automatic send_key(input logic signed [KEY_W-1:0] key, input int idle_pct);
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        start       <= 1'b1;
        i_key_value <= key;
        do @(posedge i_clk); while (busy);
        track_key(key);
    endtask

    initial begin
        logic signed [KEY_W-1:0] directed_keys [23];
        int                      phase_idle [3];
        logic signed [KEY_W-1:0] key;
        // root -1, spines down both sides, extremes at the leaves, then
        // duplicates of the extremes (no room) and of a deep node, then zero
        directed_keys = '{32'shffff_ffff,
                          32'sh4000_0000, 32'sh6000_0000, 32'sh7000_0000, 32'sh7800_0000,
                          32'sh7c00_0000, 32'sh7e00_0000, 32'sh7f00_0000, 32'sh7f80_0000,
                          KEY_MAX, KEY_MAX,
                          32'shc000_0000, 32'sha000_0000, 32'sh9000_0000, 32'sh8800_0000,
                          32'sh8400_0000, 32'sh8200_0000, 32'sh8100_0000, 32'sh8080_0000,
                          KEY_MIN, KEY_MIN,
                          32'sh7f80_0000, 32'sh0000_0000};
        phase_idle = '{0, 84, 32};

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_keys[n])
            send_key(directed_keys[n], 0);

        // mostly aimed inserts until the tree is full, the rest noise
        foreach (phase_idle[p]) begin
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                if (!tree_full[0] && $urandom_range(99) < 80)
                    key = aimed_key();
                else
                    key = noise_key();
                send_key(key, phase_idle[p]);
            end
        end
        start <= 1'b0;
        @(posedge i_clk);

        // drain, then wait for stray beats
        for (int n = 0; n < 1000 && pending_inserts != 0; n++)
            @(posedge i_clk);
        repeat (4 * LEVELS) @(posedge i_clk);

        if (mismatch_count == 0 && pending_inserts == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
